// ----- src/cce_pkg.sv -----
// Package with shared types, constants and arithmetic helpers for the Chebyshev evaluator.
package cce_pkg;

  localparam int MaxCoeffs = 16;
  localparam int IdxW      = $clog2(MaxCoeffs);
  localparam int NumAxes   = 3;
  localparam int CntW      = $clog2(MaxCoeffs + 1);

  localparam logic ActLoad = 1'b0;
  localparam logic ActEval = 1'b1;

  localparam logic [1:0] RegNumCoeff = 2'd0;
  localparam logic [1:0] RegStart    = 2'd1;
  localparam logic [1:0] RegEnd      = 2'd2;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_MUL,
    ST_DONE
  } state_t;

  // Control handed from the sequencer to each axis cell.
  typedef struct packed {
    logic       clear;   // zero f1 and f2 at the start of an evaluation
    logic       step;    // apply one recurrence step with the fetched coefficient
    logic       last;    // final step uses tau instead of 2*tau
    logic       accum;   // add the partial product of the previous phase
  } cell_ctrl_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_add = s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) sat_sub = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_sub = s[63:0];
  endfunction

endpackage

// ----- src/chebyshev_3d_clenshaw_eval.sv -----
// Top level of the three-axis Chebyshev series evaluator.
// A transfer is accepted when start is high and busy is low. action 0 loads
// coeff_value into the store at axis and coeff_index and finishes at once;
// action 1 evaluates the three series at eval_time.
// An evaluation first checks eval_time against the interval registers. A time
// outside gives status 1 with zero values, found in ST_DIV and registered with done.
// Otherwise tau is formed by a bit-serial divider, which skips its serial loop when
// the span is zero or |2t - start - end| reaches it. Then the three axis cells
// run the recurrence in lock step, one step per coefficient; each step has a
// fetch state that reads the coefficient from the store and a multiply state
// for the four 32x32 partial products of the 64-bit multiply and the update.
// The coefficient count is limited to 1..16. The result stands on pos_x, pos_y,
// pos_z and status for one cycle while done is high; the receiver cannot stall,
// so busy falls right after. Configuration writes go through cfg_we, cfg_index
// and cfg_data; the user must make them only while idle, as the block does not
// enforce it. Synchronous reset returns the control to idle and the registers
// to their reset values; the coefficient store is not cleared.
module chebyshev_3d_clenshaw_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [63:0] cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic        [1:0]  axis,
  input  logic        [3:0]  coeff_index,
  input  logic signed [63:0] coeff_value,
  input  logic signed [63:0] eval_time,
  output logic               done,
  output logic signed [63:0] pos_x,
  output logic signed [63:0] pos_y,
  output logic signed [63:0] pos_z,
  output logic               status
);
  import cce_pkg::*;

  logic [4:0]         num_coeff;
  logic signed [63:0] interval_start, interval_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_coeff      <= 5'd1;
      interval_start <= '0;
      interval_end   <= 64'sd4294967296;
    end else if (cfg_we) begin
      case (cfg_index)
        RegNumCoeff: num_coeff      <= cfg_data[4:0];
        RegStart:    interval_start <= cfg_data;
        RegEnd:      interval_end   <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Coefficient store, one memory per axis so the three cells fetch together.
  logic signed [63:0] mem_x [MaxCoeffs];
  logic signed [63:0] mem_y [MaxCoeffs];
  logic signed [63:0] mem_z [MaxCoeffs];
  logic signed [63:0] cx, cy, cz;
  logic [IdxW-1:0]    rd_idx;

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept && action == ActLoad) begin
      case (axis)
        2'd0:    mem_x[coeff_index[IdxW-1:0]] <= coeff_value;
        2'd1:    mem_y[coeff_index[IdxW-1:0]] <= coeff_value;
        2'd2:    mem_z[coeff_index[IdxW-1:0]] <= coeff_value;
        default: ;
      endcase
    end
    cx <= mem_x[rd_idx];
    cy <= mem_y[rd_idx];
    cz <= mem_z[rd_idx];
  end

  state_t state, state_next;
  logic signed [63:0] t_reg;
  logic [CntW-1:0] n_eff, step_idx;
  logic [2:0]      sub;
  logic            out_range;
  logic [63:0]     da, db, dnum, dden;
  logic            dneg, div_done, div_go;
  logic [62:0]     div_q;
  logic signed [63:0] tau;
  cell_ctrl_t      ctrl;
  logic signed [63:0] vx, vy, vz;

  assign da   = 64'(t_reg - interval_start);
  assign db   = 64'(interval_end - t_reg);
  assign dden = da + db;
  assign dneg = db > da;
  assign dnum = dneg ? db - da : da - db;

  always_ff @(posedge clk) begin
    if (accept) begin
      t_reg <= eval_time;
      if (num_coeff == 5'd0) n_eff <= CntW'(1);
      else if (num_coeff > 5'(MaxCoeffs)) n_eff <= CntW'(MaxCoeffs);
      else n_eff <= CntW'(num_coeff);
    end
  end

  assign out_range = (t_reg < interval_start) || (interval_end < t_reg);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && action == ActEval) state_next = ST_DIV;
      ST_DIV:   if (out_range) state_next = ST_DONE;
                else if (div_done) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_MUL;
      ST_MUL:   if (sub == 3'd5) state_next = (step_idx == '0) ? ST_DONE : ST_FETCH;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer: div_go pulses once, sub counts the cycles of a step.
  logic div_started;
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      div_started <= 1'b0;
    end else begin
      state <= state_next;
      div_started <= (state == ST_DIV);
    end
    if (state == ST_DIV && div_done) begin
      tau      <= dneg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      step_idx <= n_eff - CntW'(1);
    end
    if (state == ST_FETCH) sub <= 3'd0;
    else if (state == ST_MUL) begin
      sub <= sub + 3'd1;
      if (sub == 3'd5 && step_idx != '0) step_idx <= step_idx - CntW'(1);
    end
  end

  assign div_go = (state == ST_DIV) && !div_started && !out_range;
  assign rd_idx = step_idx[IdxW-1:0];

  cce_divider u_div (
    .clk (clk), .rst (rst), .go (div_go), .num (dnum), .den (dden),
    .done (div_done), .quo (div_q)
  );

  // Cell timing: sub 0 issues phase 0 product, accumulate lands sub 1..4, step at sub 5.
  // The cells are cleared in the first fetch cycle, once tau is in its register.
  logic [1:0] phase;
  always_comb begin
    ctrl.clear = (state == ST_FETCH) && (step_idx == n_eff - CntW'(1));
    ctrl.step  = (state == ST_MUL) && (sub == 3'd5) && (step_idx != '0);
    ctrl.last  = (step_idx == '0);
    ctrl.accum = (state == ST_MUL) && (sub inside {[3'd1:3'd4]});
    phase      = sub[1:0];
    if (sub == 3'd4) phase = 2'd0;
  end

  cce_cell u_cx (.clk(clk), .ctrl(ctrl), .phase(phase), .tau(tau), .coeff(cx), .value(vx));
  cce_cell u_cy (.clk(clk), .ctrl(ctrl), .phase(phase), .tau(tau), .coeff(cy), .value(vy));
  cce_cell u_cz (.clk(clk), .ctrl(ctrl), .phase(phase), .tau(tau), .coeff(cz), .value(vz));

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == ST_DIV && out_range) ||
                 (state == ST_MUL && sub == 3'd5 && step_idx == '0);
    if (state == ST_DIV && out_range) begin
      pos_x <= '0; pos_y <= '0; pos_z <= '0; status <= StatusRange;
    end else begin
      pos_x <= vx; pos_y <= vy; pos_z <= vz; status <= StatusOk;
    end
  end

  always_comb begin
    busy = (state != ST_IDLE) || done;
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> busy) else $error("busy low while working");
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == StatusRange) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0))
    else $error("out-of-range result not zero");
endmodule

// ----- src/cce_divider.sv -----
// Restoring divider that forms the magnitude of tau one quotient bit per cycle.
module cce_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [62:0] quo
);
  logic [63:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [64:0] sh;

  assign sh = {rem, 1'b0};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (go) begin
      rem <= num;
      quo <= '0;
      cnt <= 6'd0;
      if (den == 64'd0) begin
        quo <= '0;
        done <= 1'b1;
      end else if (num >= den) begin
        quo <= {1'b1, 62'd0};
        done <= 1'b1;
      end else begin
        run <= 1'b1;
      end
    end else if (run) begin
      if (cnt == 6'd62) begin
        run <= 1'b0;
        done <= 1'b1;
        if (rem[63] || {rem, 1'b0} >= {1'b0, den}) quo <= quo + 63'd1;
      end else begin
        cnt <= cnt + 6'd1;
        if (sh >= {1'b0, den}) begin
          rem <= 64'(sh - {1'b0, den});
          quo <= {quo[61:0], 1'b1};
        end else begin
          rem <= sh[63:0];
          quo <= {quo[61:0], 1'b0};
        end
      end
    end
  end
endmodule

// ----- src/cce_cell.sv -----
// One axis cell: holds f1 and f2 and applies one Clenshaw step using a multiply built from four 32x32 partial products.
module cce_cell (
  input  logic                clk,
  input  cce_pkg::cell_ctrl_t ctrl,
  input  logic        [1:0]   phase,
  input  logic signed [63:0]  tau,
  input  logic signed [63:0]  coeff,
  output logic signed [63:0]  value
);
  import cce_pkg::*;

  logic signed [63:0] f1, f2;
  logic [63:0]  am, bm;
  logic         neg;
  logic [127:0] acc;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] rnd;
  logic [63:0]  rl;
  logic         ovf;
  logic signed [63:0] prod;

  // One 32x32 partial product per phase.
  always_comb begin
    pa = phase[0] ? am[63:32] : am[31:0];
    pb = phase[1] ? bm[63:32] : bm[31:0];
  end

  always_comb begin
    if (ctrl.last) rnd = acc + (128'd1 << 61);
    else           rnd = acc + (128'd1 << 60);
    if (ctrl.last) rl = rnd[125:62]; else rl = rnd[124:61];
    if (ctrl.last) ovf = rnd[127:126] != 2'd0; else ovf = rnd[127:125] != 3'd0;
    if (neg) ovf = ovf || rl > {1'b1, 63'd0};
    else     ovf = ovf || rl[63];
    if (ovf)      prod = neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else if (neg) prod = 64'(-rl);
    else          prod = rl;
  end

  assign value = sat_add(sat_sub(prod, f2), coeff);

  always_ff @(posedge clk) begin
    pp <= pa * pb;
    if (ctrl.clear) begin
      f1  <= '0;
      f2  <= '0;
      am  <= '0;
      bm  <= tau[63] ? 64'(-tau) : tau;
      neg <= 1'b0;
      acc <= '0;
    end else if (ctrl.step) begin
      f2  <= f1;
      f1  <= value;
      am  <= value[63] ? 64'(-value) : value;
      neg <= value[63] != tau[63];
      acc <= '0;
    end else if (ctrl.accum) begin
      // The partial product of the previous phase arrives through the pp register.
      case (phase)
        2'd1:    acc <= acc + {64'd0, pp};
        2'd2:    acc <= acc + {32'd0, pp, 32'd0};
        2'd3:    acc <= acc + {32'd0, pp, 32'd0};
        default: acc <= acc + {pp, 64'd0};
      endcase
    end
  end
endmodule
